// ----- hdl/pese_pkg.sv -----
// Package for the prefix expression stack evaluator: request and result
// structs, mode and status codes, sequencer states. No dependencies.
`default_nettype none
package pese_pkg;
  localparam int STACK_DEPTH = 32;
  localparam int SP_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_PUSH = 3'd0, MODE_ADD = 3'd1, MODE_SUB = 3'd2, MODE_MUL = 3'd3,
    MODE_DIV = 3'd4, MODE_POW = 3'd5, MODE_MOD = 3'd6, MODE_NOP = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_UNDERFLOW = 3'd1, ST_OVERFLOW = 3'd2,
    ST_DIVZERO = 3'd3, ST_INVALID = 3'd4, ST_ANSWER = 3'd5
  } status_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [30:0] operand_value;
    logic        last_token;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] answer;
    logic        done_res;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RDA, S_RDB, S_OPER, S_DIV, S_POW, S_WRITE, S_TOPRD, S_TOPWT,
    S_REPORT
  } state_t;
endpackage
`default_nettype wire

// ----- hdl/pese_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pese_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hdl/prefix_expression_stack_evaluator_unit.sv -----
// Top level of the prefix expression stack evaluator: sequencer, stack RAM,
// serial divider and square-and-multiply power. Uses pese_pkg and pese_ram.
//
// Channel   Signals              Direction  Notes
// request   start, busy, req     in/out     taken when start and not busy
// result    res_valid, res       out        one cycle strobe, no backpressure
//
// Divide and modulo take one quotient bit a cycle and power one exponent bit a
// cycle, so they run longer than push, add, subtract and multiply. The
// single-read stack RAM sets the operand fetch cost.
// Reset clears the count, error and sequencer; stack contents stay undefined.
// The receiver cannot stall; busy covers one request from start to result.
`default_nettype none
module prefix_expression_stack_evaluator_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire pese_pkg::req_t  req,
  output logic                 res_valid,
  output pese_pkg::res_t       res
);
  localparam int SPW = pese_pkg::SP_W;
  localparam int CW = pese_pkg::CNT_W;

  pese_pkg::state_t state, state_next;
  pese_pkg::req_t   cur;
  logic [CW-1:0]    cnt;
  logic [2:0]       err;
  logic [31:0]      a, b, r, acc, sq, rem, quo;
  logic [31:0]      mb;
  logic [5:0]       step;
  logic [63:0]      pr;

  logic             we;
  logic [SPW-1:0]   waddr, raddr;
  logic [31:0]      wdata, rdata;

  pese_ram #(.WIDTH(32), .DEPTH(pese_pkg::STACK_DEPTH)) u_stack (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [CW-1:0] top_idx;
  assign top_idx = cnt - CW'(1);
  logic [32:0]   trial;
  assign trial = {rem, quo[31]} - {1'b0, mb};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pese_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy = (state != pese_pkg::S_IDLE);
    we = 1'b0;
    waddr = top_idx[SPW-1:0];
    wdata = {1'b0, cur.operand_value};
    raddr = top_idx[SPW-1:0];
    unique case (state)
      pese_pkg::S_IDLE: begin
        if (start) begin
          state_next = pese_pkg::S_OPER;
        end
      end
      pese_pkg::S_OPER: begin
        priority if (err != 3'd0 || cur.mode == pese_pkg::MODE_NOP) begin
          state_next = pese_pkg::S_TOPRD;
        end else if (cur.mode == pese_pkg::MODE_PUSH) begin
          if (cnt < CW'(pese_pkg::STACK_DEPTH)) begin
            we = 1'b1;
            waddr = cnt[SPW-1:0];
          end
          state_next = pese_pkg::S_TOPRD;
        end else if (cnt < CW'(2)) begin
          state_next = pese_pkg::S_TOPRD;
        end else begin
          state_next = pese_pkg::S_RDA;
        end
      end
      pese_pkg::S_RDA: begin
        raddr = SPW'(cnt - CW'(2));
        state_next = pese_pkg::S_RDB;
      end
      pese_pkg::S_RDB: begin
        if (rdata == 32'd0 &&
            (cur.mode == pese_pkg::MODE_DIV || cur.mode == pese_pkg::MODE_MOD)) begin
          state_next = pese_pkg::S_TOPRD;
        end else if (cur.mode == pese_pkg::MODE_DIV || cur.mode == pese_pkg::MODE_MOD) begin
          state_next = pese_pkg::S_DIV;
        end else if (cur.mode == pese_pkg::MODE_POW) begin
          state_next = pese_pkg::S_POW;
        end else begin
          state_next = pese_pkg::S_WRITE;
        end
      end
      pese_pkg::S_DIV: begin
        if (step == 6'd31) begin
          state_next = pese_pkg::S_WRITE;
        end
      end
      pese_pkg::S_POW: begin
        if (b == 32'd0 || b[31]) begin
          state_next = pese_pkg::S_WRITE;
        end
      end
      pese_pkg::S_WRITE: begin
        we = 1'b1;
        waddr = SPW'(top_idx - CW'(1));
        wdata = r;
        state_next = pese_pkg::S_TOPRD;
      end
      pese_pkg::S_TOPRD: begin
        raddr = cur.last_token ? '0 : top_idx[SPW-1:0];
        state_next = pese_pkg::S_TOPWT;
      end
      pese_pkg::S_TOPWT: begin
        state_next = pese_pkg::S_REPORT;
      end
      pese_pkg::S_REPORT: begin
        state_next = pese_pkg::S_IDLE;
      end
      default: begin
        state_next = pese_pkg::S_IDLE;
      end
    endcase
  end

  assign pr = 64'(acc) * 64'(sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      err <= 3'd0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      unique case (state)
        pese_pkg::S_IDLE: begin
          if (start) begin
            cur <= req;
          end
        end
        pese_pkg::S_OPER: begin
          if (err == 3'd0 && cur.mode == pese_pkg::MODE_PUSH) begin
            if (cnt < CW'(pese_pkg::STACK_DEPTH)) begin
              cnt <= cnt + CW'(1);
            end else begin
              err <= pese_pkg::ST_OVERFLOW;
            end
          end else if (err == 3'd0 && cur.mode != pese_pkg::MODE_NOP && cnt < CW'(2)) begin
            err <= pese_pkg::ST_UNDERFLOW;
          end
        end
        pese_pkg::S_RDA: begin
        end
        pese_pkg::S_RDB: begin
        end
        pese_pkg::S_DIV, pese_pkg::S_POW, pese_pkg::S_WRITE, pese_pkg::S_TOPRD: begin
        end
        pese_pkg::S_TOPWT: begin
        end
        pese_pkg::S_REPORT: begin
        end
        default: begin
        end
      endcase

      if (state == pese_pkg::S_WRITE) begin
        cnt <= cnt - CW'(1);
      end

      if (state == pese_pkg::S_REPORT) begin
        res_valid <= 1'b1;
        res.done_res <= cur.last_token;
        if (cur.last_token) begin
          if (err != 3'd0) begin
            res.status <= err;
            res.answer <= 32'd0;
          end else if (cnt == CW'(1)) begin
            res.status <= pese_pkg::ST_ANSWER;
            res.answer <= rdata;
          end else begin
            res.status <= pese_pkg::ST_INVALID;
            res.answer <= 32'd0;
          end
          cnt <= '0;
          err <= 3'd0;
        end else begin
          res.status <= err;
          res.answer <= (cnt != '0) ? rdata : 32'd0;
        end
      end

      if (state == pese_pkg::S_RDB && rdata == 32'd0 &&
          (cur.mode == pese_pkg::MODE_DIV || cur.mode == pese_pkg::MODE_MOD)) begin
        err <= pese_pkg::ST_DIVZERO;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    unique case (state)
      pese_pkg::S_RDA: begin
        b <= rdata;
      end
      pese_pkg::S_RDB: begin
        // rdata is b here; a was read first and held in b.
        a <= b;
        b <= rdata;
        acc <= 32'd1;
        sq <= b;
        rem <= 32'd0;
        quo <= b[31] ? (32'd0 - b) : b;
        mb <= rdata[31] ? (32'd0 - rdata) : rdata;
        step <= 6'd0;
        unique case (cur.mode)
          pese_pkg::MODE_ADD: r <= b + rdata;
          pese_pkg::MODE_SUB: r <= b - rdata;
          pese_pkg::MODE_MUL: r <= 32'(64'(b) * 64'(rdata));
          default: r <= 32'd0;
        endcase
      end
      pese_pkg::S_DIV: begin
        step <= step + 6'd1;
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        if (step == 6'd31) begin
          if (cur.mode == pese_pkg::MODE_DIV) begin
            r <= (a[31] != b[31]) ? 32'd0 - {quo[30:0], !trial[32]}
                                  : {quo[30:0], !trial[32]};
          end else begin
            r <= a[31] ? 32'd0 - (trial[32] ? {rem[30:0], quo[31]} : trial[31:0])
                       : (trial[32] ? {rem[30:0], quo[31]} : trial[31:0]);
          end
        end
      end
      pese_pkg::S_POW: begin
        if (b[31]) begin
          if (a == 32'd1) r <= 32'd1;
          else if (a == 32'hFFFF_FFFF) r <= b[0] ? 32'hFFFF_FFFF : 32'd1;
          else r <= 32'd0;
        end else if (b == 32'd0) begin
          r <= acc;
        end else begin
          if (b[0]) acc <= pr[31:0];
          sq <= 32'(64'(sq) * 64'(sq));
          b <= {1'b0, b[31:1]};
        end
      end
      default: begin
      end
    endcase
  end

  property p_result_after_busy;
    @(posedge clk) disable iff (rst) res_valid |-> !busy;
  endproperty
  assert property (p_result_after_busy) else $error("result while busy");

  property p_count_bound;
    @(posedge clk) disable iff (rst) cnt <= CW'(pese_pkg::STACK_DEPTH);
  endproperty
  assert property (p_count_bound) else $error("stack count out of range");

  property p_last_clears;
    @(posedge clk) disable iff (rst)
      (res_valid && res.done_res) |-> (cnt == '0 && err == 3'd0);
  endproperty
  assert property (p_last_clears) else $error("last token did not clear");

  property p_start_accepted;
    @(posedge clk) disable iff (rst) (start && !busy) |=> busy;
  endproperty
  assert property (p_start_accepted) else $error("request not taken");
endmodule
`default_nettype wire

// ----- dv/prefix_expression_stack_evaluator_unit_tb.sv -----
// Testbench for prefix_expression_stack_evaluator_unit: drives token requests
// and checks every result against a built-in stack evaluator. Uses pese_pkg.
`timescale 1ns / 100ps
`default_nettype none
module prefix_expression_stack_evaluator_unit_tb;

  class eval_scoreboard;
    logic [31:0] stack_mem [pese_pkg::STACK_DEPTH];
    int depth;
    logic [2:0] fault;
    pese_pkg::res_t pending [$];
    int errors;

    function new();
      depth = 0;
      fault = pese_pkg::ST_OK;
      errors = 0;
    endfunction

    function logic [31:0] raise_to(logic [31:0] base, logic [31:0] expo);
      logic [31:0] acc;
      logic [31:0] sq;
      acc = 1;
      sq = base;
      if (expo[31]) begin
        if (base == 32'd1) return 32'd1;
        if (base == 32'hFFFF_FFFF) return expo[0] ? 32'hFFFF_FFFF : 32'd1;
        return 32'd0;
      end
      while (expo != 0) begin
        if (expo[0]) acc = acc * sq;
        sq = sq * sq;
        expo = expo >> 1;
      end
      return acc;
    endfunction

    function void apply_operator(pese_pkg::mode_t m);
      logic [31:0] a, b, r, ma, mb, q, rm;
      if (depth < 2) begin
        fault = pese_pkg::ST_UNDERFLOW;
        return;
      end
      a = stack_mem[depth - 1];
      b = stack_mem[depth - 2];
      if ((m == pese_pkg::MODE_DIV || m == pese_pkg::MODE_MOD) && b == 0) begin
        fault = pese_pkg::ST_DIVZERO;
        return;
      end
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      rm = ma % mb;
      case (m)
        pese_pkg::MODE_ADD: r = a + b;
        pese_pkg::MODE_SUB: r = a - b;
        pese_pkg::MODE_MUL: r = a * b;
        pese_pkg::MODE_POW: r = raise_to(a, b);
        pese_pkg::MODE_DIV: r = (a[31] != b[31]) ? -q : q;
        default: r = a[31] ? -rm : rm;
      endcase
      depth = depth - 1;
      stack_mem[depth - 1] = r;
    endfunction

    function void note_request(pese_pkg::req_t rq);
      pese_pkg::res_t e;
      pese_pkg::mode_t m;
      m = pese_pkg::mode_t'(rq.mode);
      e = '0;
      if (fault == pese_pkg::ST_OK) begin
        if (m == pese_pkg::MODE_PUSH) begin
          if (depth >= pese_pkg::STACK_DEPTH) fault = pese_pkg::ST_OVERFLOW;
          else begin
            stack_mem[depth] = {1'b0, rq.operand_value};
            depth = depth + 1;
          end
        end else if (m != pese_pkg::MODE_NOP) begin
          apply_operator(m);
        end
      end
      e.done_res = rq.last_token;
      if (rq.last_token) begin
        if (fault != pese_pkg::ST_OK) e.status = fault;
        else if (depth == 1) begin
          e.status = pese_pkg::ST_ANSWER;
          e.answer = stack_mem[0];
        end else e.status = pese_pkg::ST_INVALID;
        depth = 0;
        fault = pese_pkg::ST_OK;
      end else begin
        e.status = fault;
        if (depth > 0) e.answer = stack_mem[depth - 1];
      end
      pending.push_back(e);
    endfunction

    function void check_result(pese_pkg::res_t got);
      pese_pkg::res_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, e.status));
      if (got.answer !== e.answer)
        report_mismatch($sformatf("answer %0d, want %0d",
                                  $signed(got.answer), $signed(e.answer)));
      if (got.done_res !== e.done_res)
        report_mismatch($sformatf("done_res %0b, want %0b", got.done_res, e.done_res));
    endfunction

    function void report_mismatch(string msg);
      errors++;
      if (errors <= 50) $display("mismatch at %0t: %s", $time, msg);
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  pese_pkg::req_t req = '0;
  logic res_valid;
  pese_pkg::res_t res;
  int sender_idle_pct = 0;
  int stall_cycles = 0;
  bit timed_out = 0;

  eval_scoreboard board = new();

  prefix_expression_stack_evaluator_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .res_valid(res_valid), .res(res)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && res_valid) board.check_result(res);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || res_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("watchdog expired");
      $display("prefix_expression_stack_evaluator_unit_tb failed");
      $finish;
    end
  end

  task automatic send_token(pese_pkg::mode_t m, logic [30:0] v, logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req <= '{mode: m, operand_value: v, last_token: last};
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(req);
  endtask

  function automatic logic [30:0] pick_literal();
    case ($urandom_range(5))
      0: return 31'($urandom_range(3));
      1: return 31'(32'h7FFF_FFFF - $urandom_range(3));
      2: return 31'($urandom_range(40));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic pese_pkg::mode_t pick_operator();
    return pese_pkg::mode_t'(3'($urandom_range(6, 1)));
  endfunction

  // Well-formed prefix expression, tokens sent right to left.
  task automatic send_expression(int n_ops);
    int held;
    held = 0;
    for (int k = 0; k < 2 * n_ops + 1; k++) begin
      if (held >= 2 && (k == 2 * n_ops || $urandom_range(1)) &&
          (2 * n_ops + 1 - k) >= 1 && held - 1 + (2 * n_ops - k) >= 0 &&
          ((2 * n_ops - k) - (held - 1)) <= 2 * n_ops) begin
        send_token(pick_operator(), 31'($urandom), k == 2 * n_ops);
        held--;
      end else if ((2 * n_ops - k) >= held) begin
        send_token(pese_pkg::MODE_PUSH, pick_literal(), k == 2 * n_ops);
        held++;
      end else begin
        send_token(pick_operator(), 31'($urandom), k == 2 * n_ops);
        held--;
      end
    end
  endtask

  task automatic send_noise(int len);
    for (int k = 0; k < len; k++)
      send_token(pese_pkg::mode_t'(3'($urandom_range(7))), 31'($urandom), k == len - 1);
  endtask

  task automatic directed_tests();
    send_token(pese_pkg::MODE_PUSH, 31'h7FFF_FFFF, 1'b1);
    send_token(pese_pkg::MODE_PUSH, 31'h7FFF_FFFF, 1'b0);
    send_token(pese_pkg::MODE_PUSH, 31'h7FFF_FFFF, 1'b0);
    send_token(pese_pkg::MODE_ADD, 31'h5555_5555, 1'b1);
    send_token(pese_pkg::MODE_PUSH, 31'd0, 1'b0);
    send_token(pese_pkg::MODE_PUSH, 31'd7, 1'b0);
    send_token(pese_pkg::MODE_DIV, 31'd0, 1'b1);
    send_token(pese_pkg::MODE_PUSH, 31'd1, 1'b0);
    send_token(pese_pkg::MODE_PUSH, 31'd0, 1'b0);
    send_token(pese_pkg::MODE_SUB, 31'd0, 1'b0);
    send_token(pese_pkg::MODE_POW, 31'd0, 1'b1);
    send_token(pese_pkg::MODE_ADD, 31'h2AAA_AAAA, 1'b0);
    send_token(pese_pkg::MODE_NOP, 31'd5, 1'b1);
    send_token(pese_pkg::MODE_PUSH, 31'd3, 1'b0);
    send_token(pese_pkg::MODE_PUSH, 31'd1, 1'b0);
    send_token(pese_pkg::MODE_PUSH, 31'd0, 1'b0);
    send_token(pese_pkg::MODE_SUB, 31'd0, 1'b0);
    send_token(pese_pkg::MODE_MOD, 31'd0, 1'b0);
    send_token(pese_pkg::MODE_MUL, 31'd0, 1'b1);
    for (int k = 0; k <= pese_pkg::STACK_DEPTH; k++)
      send_token(pese_pkg::MODE_PUSH, 31'(k), k == pese_pkg::STACK_DEPTH);
  endtask

  // Builds -2^31 and -1, then applies m with -2^31 as a and -1 as b: divide, remainder or power.
  task automatic corner_tests(pese_pkg::mode_t m);
    send_token(pese_pkg::MODE_PUSH, 31'd1, 1'b0);
    send_token(pese_pkg::MODE_PUSH, 31'd0, 1'b0);
    send_token(pese_pkg::MODE_SUB, 31'd0, 1'b0);
    send_token(pese_pkg::MODE_PUSH, 31'h4000_0000, 1'b0);
    send_token(pese_pkg::MODE_PUSH, 31'h4000_0000, 1'b0);
    send_token(pese_pkg::MODE_ADD, 31'd0, 1'b0);
    send_token(m, 31'd0, 1'b1);
  endtask

  initial begin
    int rounds;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_tests();
    corner_tests(pese_pkg::MODE_DIV);
    corner_tests(pese_pkg::MODE_MOD);
    corner_tests(pese_pkg::MODE_POW);
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct = (phase == 1) ? 53 : (phase == 3) ? 17 : 0;
      rounds = 0;
      while (rounds < 400) begin
        if ($urandom_range(9) < 8) begin
          int n_ops;
          n_ops = ($urandom_range(9) == 0) ? $urandom_range(16, 8) : $urandom_range(4);
          send_expression(n_ops);
          rounds += 2 * n_ops + 1;
        end else begin
          int len;
          len = $urandom_range(6, 1);
          send_noise(len);
          rounds += len;
        end
      end
    end
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0) $display("prefix_expression_stack_evaluator_unit_tb passed");
    else $display("prefix_expression_stack_evaluator_unit_tb failed");
    $finish;
  end
endmodule
`default_nettype wire

// ----- prefix_expression_stack_evaluator_unit.f -----
hdl/pese_pkg.sv
hdl/pese_ram.sv
hdl/prefix_expression_stack_evaluator_unit.sv
dv/prefix_expression_stack_evaluator_unit_tb.sv
